// ===== design/nebs_pkg.sv =====
// shared types and fixed constants of the exponential balance newton solver
`default_nettype none
package nebs_pkg;

    // request to the shared long divider
    typedef struct packed {
        logic start;
        logic frac;      // append 32 zero fraction bits to the dividend
    } t_div_req;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;      // one-cycle pulse, result valid from then on
    } t_unit_sts;

    // register indexes of the configuration port
    localparam logic CFG_STEP_TOLERANCE  = 1'b0;
    localparam logic CFG_ITERATION_LIMIT = 1'b1;

    localparam logic [15:0] TOL_RESET   = 16'd13;
    localparam logic [5:0]  LIMIT_RESET = 6'd50;

    // internal fixed point: 32 fraction bits in 64-bit words
    localparam int          QI       = 32;
    localparam logic [63:0] ONE_Q    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LN2_Q    = 64'h0000_0000_B172_17F8;
    localparam logic [63:0] EXP_CAP  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] PROD_CAP = 64'h2000_0000_0000_0000;
    localparam logic [63:0] STEP_CAP = 64'h2000_0000_0000_0000;
    localparam logic [63:0] TERM_ONE = 64'h1000_0000_0000_0000;  // 1.0 in Q.60
    localparam int          TAYLOR_TERMS = 25;

endpackage
`default_nettype wire

// ===== design/nebs_if.sv =====
// valid/ready channels for ratio words and result words
`default_nettype none
interface nebs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] ratio_in;
    modport source (output valid, output ratio_in, input ready);
    modport sink   (input valid, input ratio_in, output ready);
endinterface

interface nebs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] root_out;
    logic               converged;
    logic               saturated;
    logic [5:0]         iterations_used;
    modport source (output valid, output root_out, output converged,
                    output saturated, output iterations_used, input ready);
    modport sink   (input valid, input root_out, input converged,
                    input saturated, input iterations_used, output ready);
endinterface
`default_nettype wire

// ===== design/nebs_div.sv =====
// restoring long divider, one quotient bit per cycle, 64 or 96 steps
`default_nettype none
module nebs_div (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire nebs_pkg::t_div_req i_req,
    input  wire [63:0]             i_num,
    input  wire [63:0]             i_den,
    output nebs_pkg::t_unit_sts    o_sts,
    output logic [95:0]            o_quo
);

    localparam logic [6:0] INT_STEPS  = 7'd64;
    localparam logic [6:0] FRAC_STEPS = 7'd96;

    logic [63:0] r_rem;
    logic [95:0] r_dvd;
    logic [95:0] r_quo;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        take;

    // trial subtract of the shifted partial remainder
    assign trial = {r_rem, r_dvd[95]};
    assign diff  = trial - {1'b0, r_den};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.frac ? FRAC_STEPS : INT_STEPS;
                r_rem  <= '0;
                r_dvd  <= {i_num, 32'b0};
                r_quo  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= take ? diff[63:0] : trial[63:0];
                r_dvd  <= {r_dvd[94:0], 1'b0};
                r_quo  <= {r_quo[94:0], take};
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule
`default_nettype wire

// ===== design/nebs_mul.sv =====
// 64x64 multiplier from four 32x32 partial products
`default_nettype none
module nebs_mul (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire [63:0]             i_a,
    input  wire [63:0]             i_b,
    output nebs_pkg::t_unit_sts    o_sts,
    output logic [127:0]           o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_pp;
    logic [1:0]   r_ppi;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] pp_shifted;

    // operand halves chosen by the partial product index
    assign a_part = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    // align the registered partial product
    always_comb begin
        unique case (r_ppi)
            2'd0:    pp_shifted = {64'b0, r_pp};
            2'd1,
            2'd2:    pp_shifted = {32'b0, r_pp, 32'b0};
            default: pp_shifted = {r_pp, 64'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp  <= 64'(a_part * b_part);
                    r_ppi <= r_cnt[1:0];
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + pp_shifted;
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule
`default_nettype wire

// ===== design/newton_exp_balance_solver_top.sv =====
// newton solver for exp(psi) = eps*(1-psi) over a shared divider and multiplier
//
//   port       dir   width  content
//   i_item     in    32     ratio_in, eps unsigned fixed point
//   o_result   out   40     root_out, converged, saturated, iterations_used
//   i_cfg_*    in    16     step_tolerance (index 0), iteration_limit (index 1)
//
// one word at a time; each newton iteration runs range reduction by compare and
// subtract, 25 taylor terms of a multiply and a divide each, the product, the step
// division (skipped when df is zero) and the update
// a word runs iterations_used newton iterations between load and unload
// a finished result sits in the output register; the next word is taken meanwhile
// synchronous active-low reset loads the register reset values, no clearing pass
`default_nettype none
module newton_exp_balance_solver_top #(
    parameter int RATIO_FRAC_BITS = 16,
    parameter int ROOT_FRAC_BITS  = 27
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire [15:0] i_cfg_wdata,
    nebs_in_if.sink    i_item,
    nebs_out_if.source o_result
);

    localparam int RS = nebs_pkg::QI - ROOT_FRAC_BITS;      // root to internal shift
    localparam int KW = 40 - ROOT_FRAC_BITS;                 // range reduction quotient width
    localparam int RCW = $clog2(KW + 1);                     // range reduction step count width
    localparam logic signed [63:0] PSI_MIN = -(64'sd1 <<< (63 - ROOT_FRAC_BITS));
    localparam logic signed [63:0] PSI_MAX = 64'sh7FFF_FFFF <<< RS;
    localparam logic [63:0] HALF_LSB = 64'd1 << (RS - 1);
    localparam logic [63:0] LN2_TOP  = nebs_pkg::LN2_Q << (KW - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_TMUL, S_TDIV, S_EXP, S_PMUL, S_SDIV, S_UPD, S_DONE
    } t_state;

    t_state                r_state;
    logic [15:0]           r_tol;
    logic [5:0]            r_lim;
    logic [31:0]           r_eps;
    logic signed [63:0]    r_psi;
    logic [5:0]            r_iter;
    logic                  r_conv;
    logic                  r_sat;
    logic signed [KW:0]    r_k;
    logic [31:0]           r_r;
    logic [63:0]           r_sum;
    logic [4:0]            r_n;
    logic [63:0]           r_e;
    logic                  r_omneg;
    logic                  r_fneg;
    logic [63:0]           r_step;
    // range reduction by ln2
    logic [63:0]           r_red_x;
    logic [63:0]           r_red_den;
    logic [KW-1:0]         r_red_q;
    logic [RCW-1:0]        r_red_cnt;
    // unit requests and operands
    nebs_pkg::t_div_req    r_div_req;
    logic [63:0]           r_div_num;
    logic [63:0]           r_div_den;
    logic                  r_mul_start;
    logic [63:0]           r_mul_a;
    logic [63:0]           r_mul_b;
    // output register
    logic                  r_ovalid;
    logic signed [31:0]    r_root;
    logic                  r_oconv;
    logic                  r_osat;
    logic [5:0]            r_oiter;

    nebs_pkg::t_unit_sts   div_sts;
    nebs_pkg::t_unit_sts   mul_sts;
    logic [95:0]           div_quo;
    logic [127:0]          mul_prod;

    nebs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    nebs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    // (p >> s) saturated at cap
    function automatic logic [63:0] shr_sat(input logic [127:0] p, input int s,
                                            input logic [63:0] cap);
        logic [127:0] sh;
        sh = p >> s;
        return (sh > {64'b0, cap}) ? cap : sh[63:0];
    endfunction

    logic               in_fire;
    logic               out_fire;
    logic               red_take;
    logic [KW-1:0]      red_q;
    logic [31:0]        red_rem;
    logic signed [KW:0] red_k;
    logic [31:0]        red_r;
    logic [63:0]        r60;
    logic [63:0]        term_sat;
    logic [63:0]        sum_new;
    logic signed [KW+1:0] exp_sh_full;
    logic [63:0]        sum_x2;
    logic [63:0]        exp_val;
    logic signed [63:0] om;
    logic [63:0]        om_abs;
    logic [63:0]        pmag;
    logic signed [63:0] prod_s;
    logic signed [63:0] f_val;
    logic [63:0]        fmag;
    logic [63:0]        df;
    logic [63:0]        step_sat;
    logic signed [63:0] psi_upd;
    logic signed [63:0] psi_clamp;
    logic               psi_clip;
    logic [63:0]        tol_q;
    logic [5:0]         lim_eff;
    logic [5:0]         iter_new;
    logic               stop_conv;
    logic               stop_any;
    logic [63:0]        u_out;

    assign in_fire  = i_item.valid && i_item.ready;
    assign out_fire = o_result.valid && o_result.ready;

    // range reduction psi = k*ln2 + r with 0 <= r < ln2
    assign red_take = r_red_x >= r_red_den;
    assign red_q    = r_red_q;
    assign red_rem  = r_red_x[31:0];
    always_comb begin
        if (!r_psi[63]) begin
            red_k = $signed({1'b0, red_q});
            red_r = red_rem;
        end else if (red_rem == 32'd0) begin
            red_k = -$signed({1'b0, red_q});
            red_r = 32'd0;
        end else begin
            red_k = -$signed({1'b0, red_q}) - (KW+1)'(1);
            red_r = 32'(nebs_pkg::LN2_Q[31:0] - red_rem);
        end
    end

    // taylor series terms in q.60
    assign r60      = {4'b0, r_r, 28'b0};
    assign term_sat = shr_sat(mul_prod, 60, nebs_pkg::EXP_CAP);
    assign sum_new  = r_sum + div_quo[63:0];

    // scale the series sum by 2^k
    assign exp_sh_full = (KW+2)'(28) - (KW+2)'(r_k);
    assign sum_x2      = {r_sum[62:0], 1'b0};
    always_comb begin
        if (r_k > 29) begin
            exp_val = nebs_pkg::EXP_CAP;
        end else if (r_k <= -36) begin
            exp_val = '0;
        end else if (r_k < 28) begin
            exp_val = r_sum >> exp_sh_full[5:0];
        end else if (r_k == 29) begin
            exp_val = (sum_x2 > nebs_pkg::EXP_CAP) ? nebs_pkg::EXP_CAP : sum_x2;
        end else begin
            exp_val = (r_sum > nebs_pkg::EXP_CAP) ? nebs_pkg::EXP_CAP : r_sum;
        end
    end

    // f = exp(psi) - eps*(1-psi) and df = exp(psi) + eps
    assign om     = $signed(nebs_pkg::ONE_Q) - r_psi;
    assign om_abs = om[63] ? 64'(-om) : 64'(om);
    assign pmag   = shr_sat(mul_prod, RATIO_FRAC_BITS, nebs_pkg::PROD_CAP);
    assign prod_s = r_omneg ? -$signed(pmag) : $signed(pmag);
    assign f_val  = $signed(r_e) - prod_s;
    assign fmag   = f_val[63] ? 64'(-f_val) : 64'(f_val);
    assign df     = r_e + ({32'b0, r_eps} << (nebs_pkg::QI - RATIO_FRAC_BITS));
    assign step_sat = (div_quo > {32'b0, nebs_pkg::STEP_CAP}) ? nebs_pkg::STEP_CAP
                                                              : div_quo[63:0];

    // newton update with clamp to the output range
    assign psi_upd = r_fneg ? r_psi + $signed(r_step) : r_psi - $signed(r_step);
    always_comb begin
        psi_clip = 1'b1;
        if (psi_upd < PSI_MIN) begin
            psi_clamp = PSI_MIN;
        end else if (psi_upd > PSI_MAX) begin
            psi_clamp = PSI_MAX;
        end else begin
            psi_clamp = psi_upd;
            psi_clip  = 1'b0;
        end
    end
    assign tol_q     = {48'b0, r_tol} << RS;
    assign lim_eff   = (r_lim == 6'd0) ? 6'd1 : r_lim;
    assign iter_new  = r_iter + 6'd1;
    assign stop_conv = r_step < tol_q;
    assign stop_any  = stop_conv || (iter_new >= lim_eff);

    // round psi to the output format
    assign u_out = ($unsigned(r_psi - PSI_MIN) + HALF_LSB) >> RS;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= nebs_pkg::TOL_RESET;
            r_lim       <= nebs_pkg::LIMIT_RESET;
            r_div_req   <= '0;
            r_mul_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            r_mul_start     <= 1'b0;
            if (out_fire) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    nebs_pkg::CFG_STEP_TOLERANCE:  r_tol <= i_cfg_wdata;
                    nebs_pkg::CFG_ITERATION_LIMIT: r_lim <= i_cfg_wdata[5:0];
                    default:                       r_tol <= r_tol;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_eps     <= i_item.ratio_in;
                        r_psi     <= '0;
                        r_iter    <= '0;
                        r_conv    <= 1'b0;
                        r_sat     <= 1'b0;
                        r_red_x   <= '0;
                        r_red_den <= LN2_TOP;
                        r_red_q   <= '0;
                        r_red_cnt <= RCW'(KW);
                        r_state   <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_red_cnt != '0) begin
                        if (red_take) begin
                            r_red_x <= r_red_x - r_red_den;
                        end
                        r_red_den <= r_red_den >> 1;
                        r_red_q   <= {r_red_q[KW-2:0], red_take};
                        r_red_cnt <= r_red_cnt - RCW'(1);
                    end else begin
                        r_k         <= red_k;
                        r_r         <= red_r;
                        r_sum       <= nebs_pkg::TERM_ONE;
                        r_n         <= 5'd1;
                        r_mul_start <= 1'b1;
                        r_mul_a     <= nebs_pkg::TERM_ONE;
                        r_mul_b     <= {4'b0, red_r, 28'b0};
                        r_state     <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    if (mul_sts.done) begin
                        r_div_req <= '{start: 1'b1, frac: 1'b0};
                        r_div_num <= term_sat;
                        r_div_den <= {59'b0, r_n};
                        r_state   <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_sts.done) begin
                        r_sum <= sum_new;
                        if (r_n == 5'(nebs_pkg::TAYLOR_TERMS)) begin
                            r_state <= S_EXP;
                        end else begin
                            r_n         <= r_n + 5'd1;
                            r_mul_start <= 1'b1;
                            r_mul_a     <= div_quo[63:0];
                            r_mul_b     <= r60;
                            r_state     <= S_TMUL;
                        end
                    end
                end
                S_EXP: begin
                    r_e         <= exp_val;
                    r_omneg     <= om[63];
                    r_mul_start <= 1'b1;
                    r_mul_a     <= {32'b0, r_eps};
                    r_mul_b     <= om_abs;
                    r_state     <= S_PMUL;
                end
                S_PMUL: begin
                    if (mul_sts.done) begin
                        r_fneg <= f_val[63];
                        if (df == 64'd0) begin
                            r_step  <= nebs_pkg::ONE_Q;
                            r_state <= S_UPD;
                        end else begin
                            r_div_req <= '{start: 1'b1, frac: 1'b1};
                            r_div_num <= fmag;
                            r_div_den <= df;
                            r_state   <= S_SDIV;
                        end
                    end
                end
                S_SDIV: begin
                    if (div_sts.done) begin
                        r_step  <= step_sat;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_psi  <= psi_clamp;
                    r_iter <= iter_new;
                    if (psi_clip) begin
                        r_sat <= 1'b1;
                    end
                    if (stop_conv) begin
                        r_conv <= 1'b1;
                    end
                    if (stop_any) begin
                        r_state <= S_DONE;
                    end else begin
                        r_red_x   <= psi_clamp[63] ? 64'(-psi_clamp) : 64'(psi_clamp);
                        r_red_den <= LN2_TOP;
                        r_red_q   <= '0;
                        r_red_cnt <= RCW'(KW);
                        r_state   <= S_RED;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_ovalid <= 1'b1;
                        r_root   <= $signed(u_out[31:0] ^ 32'h8000_0000);
                        r_oconv  <= r_conv;
                        r_osat   <= r_sat;
                        r_oiter  <= r_iter;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready             = (r_state == S_IDLE);
    assign o_result.valid           = r_ovalid;
    assign o_result.root_out        = r_root;
    assign o_result.converged       = r_oconv;
    assign o_result.saturated       = r_osat;
    assign o_result.iterations_used = r_oiter;

    // the two shared units never run at the same time
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_sts.busy && mul_sts.busy))
        else $error("divider and multiplier busy together");

    // psi stays inside the representable output range
    a_psi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_psi >= PSI_MIN && r_psi <= PSI_MAX))
        else $error("psi left the output range");

    // iteration count never passes the limit while solving
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_iter <= lim_eff))
        else $error("iteration count past limit");

    // an accepted word blocks the input until its result is stored
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_item.ready)
        else $error("input taken while solving");

endmodule
`default_nettype wire
